[hdl/sdtw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtw_pkg: shared types and constants
// Controller states, command/status bundles and fixed codes.
// ----------------------------------------------------------------------------
package sdtw_pkg;

   localparam logic [31:0] INF_CODE = 32'hFFFF_FFFF;
   localparam logic [31:0] SAT_MAX  = 32'hFFFF_FFFE;
   localparam int          PATTERNS = 4;   // packed fields in the step registers

   localparam logic [2:0] CSR_QUERY_LEN  = 3'd0;
   localparam logic [2:0] CSR_SUB_MODE   = 3'd1;
   localparam logic [2:0] CSR_STEP_COUNT = 3'd2;
   localparam logic [2:0] CSR_ROW_SIZES  = 3'd3;
   localparam logic [2:0] CSR_COL_SIZES  = 3'd4;
   localparam logic [2:0] CSR_WEIGHTS    = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_WRITE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       load;      // capture request, initialise accumulator
      logic       rd;        // issue history read for step k
      logic       eval;      // compare read data for step k
      logic [1:0] k;         // step index
      logic       commit;    // write history, update counters, load result
      logic       rsp_take;  // result consumed
   } cmd_type;

   typedef struct packed {
      logic       start_cell;
      logic [2:0] nsteps;
      logic       rsp_full;
   } sts_type;

endpackage

[hdl/sdtw_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtw_ctrl: sequencing controller
// Walks one request through read/compare of each step pattern and commit.
// ----------------------------------------------------------------------------
module sdtw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              rsp_ready,
   input  sdtw_pkg::sts_type sts,
   output sdtw_pkg::cmd_type cmd
);

   sdtw_pkg::state_type state_ff, state_in;
   logic [1:0]          k_ff, k_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdtw_pkg::ST_IDLE;
         k_ff     <= 2'd0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      cmd          = '0;
      cmd.k        = k_ff;
      req_ready    = 1'b0;
      cmd.rsp_take = sts.rsp_full && rsp_ready;
      unique case (state_ff)
         sdtw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               k_in     = 2'd0;
               state_in = sdtw_pkg::ST_READ;
            end
         end
         sdtw_pkg::ST_READ: begin
            // skip the search for start cells or when no step remains
            if (sts.start_cell || ({1'b0, k_ff} >= sts.nsteps)) begin
               state_in = sdtw_pkg::ST_WRITE;
            end else begin
               cmd.rd   = 1'b1;
               state_in = sdtw_pkg::ST_EVAL;
            end
         end
         sdtw_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            if (k_ff == 2'd3) begin
               state_in = sdtw_pkg::ST_WRITE;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = sdtw_pkg::ST_READ;
            end
         end
         sdtw_pkg::ST_WRITE: begin
            // hold until the output register is free
            if (!sts.rsp_full || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = sdtw_pkg::ST_OUT;
            end
         end
         sdtw_pkg::ST_OUT: begin
            state_in = sdtw_pkg::ST_IDLE;
         end
         default: state_in = sdtw_pkg::ST_IDLE;
      endcase
   end

endmodule

[hdl/sdtw_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdtw_dp: cost datapath
// History memory, position counters, step search, running best, result reg.
// ----------------------------------------------------------------------------
module sdtw_dp #(
   parameter int MAX_ROWS      = 1024,
   parameter int MAX_STEPS     = 4,
   parameter int MAX_STEP_SIZE = 3,
   parameter int COST_BITS     = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  sdtw_pkg::cmd_type cmd,
   output sdtw_pkg::sts_type sts,
   input  logic [COST_BITS-1:0] req_local_cost,
   input  logic              req_last_item,
   input  logic [10:0]       cfg_query_len,
   input  logic              cfg_sub,
   input  logic [2:0]        cfg_step_count,
   input  logic [7:0]        cfg_row_sizes,
   input  logic [7:0]        cfg_col_sizes,
   input  logic [31:0]       cfg_weights,
   output logic              rsp_valid,
   output logic [31:0]       rsp_acc_cost,
   output logic [2:0]        rsp_back_step,
   output logic              rsp_matrix_done,
   output logic [15:0]       rsp_best_column,
   output logic [31:0]       rsp_best_cost,
   output logic              rsp_best_found
);

   localparam int HIST_COLS = MAX_STEP_SIZE + 1;
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int SLOT_W    = (HIST_COLS > 1) ? $clog2(HIST_COLS) : 1;
   localparam int DEPTH     = HIST_COLS * MAX_ROWS;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int RLEN_W    = ROW_W + 1;
   localparam int NS_LIM    = (MAX_STEPS < sdtw_pkg::PATTERNS) ? MAX_STEPS
                                                               : sdtw_pkg::PATTERNS;

   logic [31:0] hist_mem [DEPTH];
   logic [31:0] rd_data_ff;

   logic [COST_BITS-1:0] cost_ff;
   logic                 last_ff;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [15:0]          col_ff, col_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [31:0]          best_cost_ff, best_cost_in;
   logic [15:0]          best_col_ff, best_col_in;
   logic [31:0]          acc_ff;
   logic [2:0]           back_ff;
   logic                 hit_ff;     // pattern at rd passed its range checks
   logic [7:0]           w_ff;

   // result register
   logic        rsp_valid_ff;
   logic [31:0] rsp_acc_ff, rsp_bcost_ff;
   logic [2:0]  rsp_back_ff;
   logic        rsp_done_ff, rsp_found_ff;
   logic [15:0] rsp_bcol_ff;

   // clamped configuration
   logic [RLEN_W-1:0] rows;
   logic [2:0]        nsteps;
   always_comb begin
      if (cfg_query_len == 11'd0)
         rows = RLEN_W'(1);
      else if ({21'd0, cfg_query_len} > 32'(MAX_ROWS))
         rows = RLEN_W'(MAX_ROWS);
      else
         rows = RLEN_W'(cfg_query_len);
      nsteps = ({29'd0, cfg_step_count} > 32'(NS_LIM)) ? 3'(NS_LIM) : cfg_step_count;
   end

   assign sts.start_cell = (row_ff == '0) && (cfg_sub || col_ff == 16'd0);
   assign sts.nsteps     = nsteps;
   assign sts.rsp_full   = rsp_valid_ff;

   // step k decode
   logic [1:0]        q_k, r_k;
   logic [7:0]        w_k;
   logic              ok_k;
   logic [SLOT_W-1:0] pslot;
   logic [ADDR_W-1:0] rd_addr;
   always_comb begin
      q_k   = cfg_row_sizes[{cmd.k, 1'b0} +: 2];
      r_k   = cfg_col_sizes[{cmd.k, 1'b0} +: 2];
      w_k   = cfg_weights[{cmd.k, 3'b000} +: 8];
      ok_k  = !(q_k == 2'd0 && r_k == 2'd0)
              && ({30'd0, r_k} <= 32'(MAX_STEP_SIZE))
              && ({{(ROW_W > 2 ? ROW_W-2 : 0){1'b0}}, q_k} <= row_ff)
              && ({14'd0, r_k} <= col_ff);
      if ({1'b0, slot_ff} >= {{(SLOT_W > 1 ? SLOT_W-1 : 0){1'b0}}, r_k})
         pslot = SLOT_W'({1'b0, slot_ff} - (SLOT_W+1)'(r_k));
      else
         pslot = SLOT_W'({1'b0, slot_ff} + (SLOT_W+1)'(HIST_COLS) - (SLOT_W+1)'(r_k));
      rd_addr = ADDR_W'(pslot) * ADDR_W'(MAX_ROWS)
                + ADDR_W'(row_ff - ROW_W'(q_k));
   end

   logic [ADDR_W-1:0] wr_addr;
   assign wr_addr = ADDR_W'(slot_ff) * ADDR_W'(MAX_ROWS) + ADDR_W'(row_ff);

   always_ff @(posedge clock) begin
      if (cmd.rd)
         rd_data_ff <= hist_mem[rd_addr];
      if (cmd.commit)
         hist_mem[wr_addr] <= acc_ff;
   end

   // weighted cost and candidate sum
   logic [COST_BITS+8:0] wprod;
   logic [32:0]          sum;
   assign wprod = ((COST_BITS+9)'(cost_ff) * (COST_BITS+9)'(w_ff)) + (COST_BITS+9)'(8);
   always_comb begin
      sum = {1'b0, rd_data_ff} + 33'(wprod >> 4);
      if (sum > {1'b0, sdtw_pkg::SAT_MAX})
         sum = {1'b0, sdtw_pkg::SAT_MAX};
   end

   // position and best updates at commit
   logic final_row;
   always_comb begin
      final_row    = ({1'b0, row_ff} + RLEN_W'(1)) >= rows;
      row_in       = row_ff;
      col_in       = col_ff;
      slot_in      = slot_ff;
      best_cost_in = best_cost_ff;
      best_col_in  = best_col_ff;
      if ({1'b0, row_ff} + RLEN_W'(1) == rows) begin
         if (!cfg_sub || acc_ff < best_cost_ff) begin
            best_cost_in = acc_ff;
            best_col_in  = col_ff;
         end
      end
      if (last_ff) begin
         row_in       = '0;
         col_in       = 16'd0;
         slot_in      = '0;
         best_cost_in = sdtw_pkg::INF_CODE;
         best_col_in  = 16'd0;
      end else if (final_row) begin
         row_in  = '0;
         col_in  = col_ff + 16'd1;
         // slot tracks col mod HIST_COLS
         slot_in = ({1'b0, slot_ff} == (SLOT_W+1)'(HIST_COLS - 1)) ? '0
                   : slot_ff + SLOT_W'(1);
         if (col_ff == 16'hFFFF) slot_in = '0;
      end else begin
         row_in = row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= 16'd0;
         slot_ff      <= '0;
         best_cost_ff <= sdtw_pkg::INF_CODE;
         best_col_ff  <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            row_ff       <= row_in;
            col_ff       <= col_in;
            slot_ff      <= slot_in;
            best_cost_ff <= best_cost_in;
            best_col_ff  <= best_col_in;
            rsp_valid_ff <= 1'b1;
         end else if (cmd.rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // best values including this cell, before the end-of-matrix clear
   function automatic logic [31:0] best_cost_pre();
      logic upd;
      upd = ({1'b0, row_ff} + RLEN_W'(1) == rows) && (!cfg_sub || acc_ff < best_cost_ff);
      return upd ? acc_ff : best_cost_ff;
   endfunction
   function automatic logic [15:0] best_col_in_pre();
      logic upd;
      upd = ({1'b0, row_ff} + RLEN_W'(1) == rows) && (!cfg_sub || acc_ff < best_cost_ff);
      return upd ? col_ff : best_col_ff;
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cost_ff <= req_local_cost;
         last_ff <= req_last_item;
         back_ff <= 3'd0;
         acc_ff  <= sts.start_cell ? 32'(req_local_cost) : sdtw_pkg::INF_CODE;
      end
      if (cmd.rd) begin
         hit_ff <= ok_k;
         w_ff   <= w_k;
      end
      if (cmd.eval && hit_ff && rd_data_ff != sdtw_pkg::INF_CODE
          && sum[31:0] < acc_ff) begin
         acc_ff  <= sum[31:0];
         back_ff <= {1'b0, cmd.k} + 3'd1;
      end
      if (cmd.commit) begin
         rsp_acc_ff   <= acc_ff;
         rsp_back_ff  <= back_ff;
         rsp_done_ff  <= last_ff;
         rsp_bcol_ff  <= last_ff ? best_col_in_pre() : 16'd0;
         rsp_bcost_ff <= last_ff ? best_cost_pre() : 32'd0;
         rsp_found_ff <= last_ff && (best_cost_pre() != sdtw_pkg::INF_CODE);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_acc_cost    = rsp_acc_ff;
   assign rsp_back_step   = rsp_back_ff;
   assign rsp_matrix_done = rsp_done_ff;
   assign rsp_best_column = rsp_bcol_ff;
   assign rsp_best_cost   = rsp_bcost_ff;
   assign rsp_best_found  = rsp_found_ff;

endmodule

[hdl/subsequence_dtw_cost_accumulator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subsequence_dtw_cost_accumulator: subsequence DTW cost accumulator
// Accumulates warping cost cell by cell, column-major, and reports the best
// final-row column at the end of each matrix.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  req      | req_valid/req_ready   | local_cost, last_item
//  rsp      | rsp_valid/rsp_ready   | acc_cost, back_step, matrix_done, best_*
//  csr      | csr_write_enable      | csr_index, csr_write_data
//
//  From acceptance to the next acceptance a request passes through the accept
//  state, a history read and a compare per step pattern in use on the
//  single-port history memory (neither for start cells), a final check when
//  fewer than four patterns are in use or for start cells, the commit and a
//  turnaround; a new request is only taken once the last one is through. The
//  response is valid the cycle after the commit. Reset clears position and
//  running best and sets the configuration to its defaults; the history memory
//  is not cleared. A full output register that is not taken stalls the commit of the next request.
// ----------------------------------------------------------------------------
module subsequence_dtw_cost_accumulator #(
   parameter int MAX_ROWS      = 1024,
   parameter int MAX_STEPS     = 4,
   parameter int MAX_STEP_SIZE = 3,
   parameter int COST_BITS     = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [COST_BITS-1:0] req_local_cost,
   input  logic                 req_last_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_acc_cost,
   output logic [2:0]           rsp_back_step,
   output logic                 rsp_matrix_done,
   output logic [15:0]          rsp_best_column,
   output logic [31:0]          rsp_best_cost,
   output logic                 rsp_best_found,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_write_data
);

   // configuration registers
   logic [10:0] query_len_ff;
   logic        sub_mode_ff;
   logic [2:0]  step_count_ff;
   logic [7:0]  row_sizes_ff, col_sizes_ff;
   logic [31:0] weights_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         query_len_ff  <= 11'd1024;
         sub_mode_ff   <= 1'b1;
         step_count_ff <= 3'd3;
         row_sizes_ff  <= 8'd37;
         col_sizes_ff  <= 8'd25;
         weights_ff    <= 32'h1010_1010;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sdtw_pkg::CSR_QUERY_LEN:  query_len_ff  <= csr_write_data[10:0];
            sdtw_pkg::CSR_SUB_MODE:   sub_mode_ff   <= csr_write_data[0];
            sdtw_pkg::CSR_STEP_COUNT: step_count_ff <= csr_write_data[2:0];
            sdtw_pkg::CSR_ROW_SIZES:  row_sizes_ff  <= csr_write_data[7:0];
            sdtw_pkg::CSR_COL_SIZES:  col_sizes_ff  <= csr_write_data[7:0];
            sdtw_pkg::CSR_WEIGHTS:    weights_ff    <= csr_write_data;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   sdtw_pkg::cmd_type cmd;
   sdtw_pkg::sts_type sts;

   sdtw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sdtw_dp #(
      .MAX_ROWS      (MAX_ROWS),
      .MAX_STEPS     (MAX_STEPS),
      .MAX_STEP_SIZE (MAX_STEP_SIZE),
      .COST_BITS     (COST_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_local_cost  (req_local_cost),
      .req_last_item   (req_last_item),
      .cfg_query_len   (query_len_ff),
      .cfg_sub         (sub_mode_ff),
      .cfg_step_count  (step_count_ff),
      .cfg_row_sizes   (row_sizes_ff),
      .cfg_col_sizes   (col_sizes_ff),
      .cfg_weights     (weights_ff),
      .rsp_valid       (rsp_valid),
      .rsp_acc_cost    (rsp_acc_cost),
      .rsp_back_step   (rsp_back_step),
      .rsp_matrix_done (rsp_matrix_done),
      .rsp_best_column (rsp_best_column),
      .rsp_best_cost   (rsp_best_cost),
      .rsp_best_found  (rsp_best_found)
   );

endmodule
